// ----- hdl/indexed_bucket_priority_queue_defines.svh -----
// Assertion macros used by the queue's datapath.
`ifndef INDEXED_BUCKET_PRIORITY_QUEUE_DEFINES_SVH
`define INDEXED_BUCKET_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IBPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ibpq check failed");

// Next-cycle implication, checked outside reset.
`define IBPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ibpq check failed");

`endif

// ----- hdl/ibpq_pkg.sv -----
// Types, constants and codes of the indexed priority queue.
package ibpq_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int PRI_W    = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ITEM_W   = 32;
  localparam int OCC_W    = 7;

  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_ERASE = 3'd2,
    REQ_FIND  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SCAN_TAIL, S_DECIDE, S_SWEEP, S_SWEEP_TAIL, S_INSERT, S_FINISH
  } fsm_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [KEY_W-1:0] item_key;
    logic [PRI_W-1:0] priority_req;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ITEM_W-1:0] item_out;
    logic [OCC_W-1:0]  occupancy;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic scan;
    logic sweep;
    logic drop;
    logic insert;
    logic clear_all;
    logic finish;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic ptr_last;
    logic need_drop;
    logic is_push;
    logic is_clear;
  } sts_t;

endpackage

// ----- hdl/ibpq_ram.sv -----
// Generic simple dual-port RAM with registered read.
module ibpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ibpq_ctrl.sv -----
// Sequencer for scan, rank sweep and insert phases of each request.
module ibpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ibpq_pkg::sts_t sts,
  output ibpq_pkg::ctl_t cmd,
  output logic          busy
);
  import ibpq_pkg::*;

  fsm_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.ptr_last) begin
          state_next = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.need_drop) begin
          cmd.drop   = 1'b1;
          state_next = S_SWEEP;
        end else if (sts.is_clear) begin
          cmd.clear_all = 1'b1;
          state_next    = S_FINISH;
        end else if (sts.is_push) begin
          state_next = S_INSERT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.ptr_last) begin
          state_next = S_SWEEP_TAIL;
        end
      end
      S_SWEEP_TAIL: state_next = sts.is_push ? S_INSERT : S_FINISH;
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- hdl/ibpq_dp.sv -----
// Slot storage, scan compare, rank sweep and result register.
`include "indexed_bucket_priority_queue_defines.svh"
module ibpq_dp (
  input  logic           clk,
  input  logic           rst,
  input  ibpq_pkg::req_t req,
  input  ibpq_pkg::ctl_t cmd,
  output ibpq_pkg::sts_t sts,
  output logic           done,
  output ibpq_pkg::rsp_t result
);
  import ibpq_pkg::*;

  req_t             cur;
  logic [CAPACITY-1:0] valid;
  logic [CNT_W-1:0] held_count;
  logic [IDX_W-1:0] ptr;
  logic             d_vld, d_sweep;
  logic [IDX_W-1:0] d_idx;

  logic             match_hit, best_hit, free_hit, full_flag;
  logic [IDX_W-1:0] match_idx, best_idx, free_idx;
  logic [IDX_W-1:0] match_rank, best_rank, drop_rank;
  logic [PRI_W-1:0] best_pri;
  logic [KEY_W-1:0] best_key;

  logic [KEY_W-1:0] key_rd;
  logic [PRI_W-1:0] pri_rd;
  logic [IDX_W-1:0] rank_rd;

  logic             slot_we, rank_we, sweep_we, d_live, better, full_now;
  logic [IDX_W-1:0] ins_idx, rank_waddr, rank_wdata, drop_sel_idx, drop_sel_rank;
  logic             is_push, is_pop, is_erase, is_find, is_clear;

  assign is_push  = (cur.req_type == REQ_PUSH);
  assign is_pop   = (cur.req_type == REQ_POP);
  assign is_erase = (cur.req_type == REQ_ERASE);
  assign is_find  = (cur.req_type == REQ_FIND);
  assign is_clear = (cur.req_type == REQ_CLEAR);

  assign sts.ptr_last  = (ptr == IDX_W'(CAPACITY - 1));
  assign sts.need_drop = ((is_push || is_erase) && match_hit) || (is_pop && best_hit);
  assign sts.is_push   = is_push;
  assign sts.is_clear  = is_clear;

  // Lowest free slot after any drop of the matched key
  assign ins_idx  = (match_hit && (!free_hit || match_idx < free_idx)) ? match_idx : free_idx;
  assign full_now = (held_count >= CNT_W'(CAPACITY));
  assign slot_we  = cmd.insert && !full_now;

  assign drop_sel_idx  = is_pop ? best_idx : match_idx;
  assign drop_sel_rank = is_pop ? best_rank : match_rank;

  // Read-back stage compare
  assign d_live   = d_vld && valid[d_idx];
  assign better   = !best_hit || (pri_rd < best_pri) ||
                    ((pri_rd == best_pri) && (rank_rd < best_rank));
  assign sweep_we = d_live && d_sweep && (rank_rd > drop_rank);
  assign rank_we  = sweep_we || slot_we;
  assign rank_waddr = slot_we ? ins_idx : d_idx;
  assign rank_wdata = slot_we ? held_count[IDX_W-1:0] : rank_rd - 1'b1;

  ibpq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(slot_we), .waddr(ins_idx), .wdata(cur.item_key),
    .raddr(ptr), .rdata(key_rd)
  );
  ibpq_ram #(.WIDTH(PRI_W), .DEPTH(CAPACITY)) u_pri_ram (
    .clk(clk), .we(slot_we), .waddr(ins_idx), .wdata(cur.priority_req),
    .raddr(ptr), .rdata(pri_rd)
  );
  ibpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(ptr), .rdata(rank_rd)
  );

  // Latch request, advance pointer, track read-back pipe
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= req;
    end
    if (cmd.load || cmd.drop) begin
      ptr <= '0;
    end else if (cmd.scan || cmd.sweep) begin
      ptr <= ptr + 1'b1;
    end
    d_idx   <= ptr;
    d_sweep <= cmd.sweep;
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= cmd.scan || cmd.sweep;
    end
  end

  // Scan results: key match, best candidate, first free slot
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      match_hit <= 1'b0;
      best_hit  <= 1'b0;
      free_hit  <= 1'b0;
      full_flag <= 1'b0;
    end else begin
      if (d_vld && !d_sweep) begin
        if (d_live && key_rd == cur.item_key) begin
          match_hit <= 1'b1;
        end
        if (d_live && better) begin
          best_hit <= 1'b1;
        end
        if (!valid[d_idx] && !free_hit) begin
          free_hit <= 1'b1;
        end
      end
      if (cmd.insert && full_now) begin
        full_flag <= 1'b1;
      end
    end
  end

  // Payload of the scan results
  always_ff @(posedge clk) begin
    if (d_vld && !d_sweep) begin
      if (d_live && key_rd == cur.item_key) begin
        match_idx  <= d_idx;
        match_rank <= rank_rd;
      end
      if (d_live && better) begin
        best_idx  <= d_idx;
        best_rank <= rank_rd;
        best_pri  <= pri_rd;
        best_key  <= key_rd;
      end
      if (!valid[d_idx] && !free_hit) begin
        free_idx <= d_idx;
      end
    end
    if (cmd.drop) begin
      drop_rank <= drop_sel_rank;
    end
  end

  // Valid bits and count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      valid      <= '0;
      held_count <= '0;
    end else if (cmd.drop) begin
      valid[drop_sel_idx] <= 1'b0;
      held_count          <= held_count - 1'b1;
    end else if (slot_we) begin
      valid[ins_idx] <= 1'b1;
      held_count     <= held_count + 1'b1;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      result.occupancy <= OCC_W'(held_count);
      result.item_out  <= '0;
      result.status    <= ST_OK;
      if (is_push && full_flag) begin
        result.status <= ST_FULL;
      end else if (is_pop) begin
        if (best_hit) begin
          result.item_out <= ITEM_W'(best_key);
        end else begin
          result.status <= ST_ABSENT;
        end
      end else if (is_erase && !match_hit) begin
        result.status <= ST_ABSENT;
      end else if (is_find) begin
        if (match_hit) begin
          result.item_out <= ITEM_W'(cur.item_key);
        end else begin
          result.status <= ST_ABSENT;
        end
      end
    end
  end

  `IBPQ_ASSERT_NOW(a_count_matches_valid, 1'b1, $countones(valid) == held_count)
  `IBPQ_ASSERT_NOW(a_drop_hits_valid, cmd.drop, valid[drop_sel_idx])
  `IBPQ_ASSERT_NOW(a_insert_into_free, slot_we, !valid[ins_idx])
  `IBPQ_ASSERT_NEXT(a_finish_gives_beat, cmd.finish, done)

endmodule

// ----- hdl/indexed_bucket_priority_queue.sv -----
// Top level of the keyed priority queue with arrival order among equal priorities.
//
// Pulse start with a request while busy is low; busy rises on the next cycle and the
// single result beat appears on result with done high for exactly one cycle, which
// the receiver must take as it comes. Each request first scans all 64 slots through
// the slot memories (one slot per cycle). A find, a clear, a miss, a pop of an empty
// queue or an unused code then finishes; a push of a new key also passes through the
// insert state, where it is stored or dropped as full. A pop, an erase of a held key
// or a push of a held key also runs a second pass over all 64 entries of the
// arrival-rank memory to close the gap in arrival order, and the push then inserts.
// busy falls in the cycle that carries done, so the next request can be taken at the
// edge that ends it.
// No clearing pass after reset.
module indexed_bucket_priority_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ibpq_pkg::req_t req,
  output logic           busy,
  output logic           done,
  output ibpq_pkg::rsp_t result
);
  import ibpq_pkg::*;

  ctl_t cmd;
  sts_t sts;

  ibpq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  ibpq_dp u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .sts(sts), .done(done), .result(result)
  );

endmodule

// ----- tb/indexed_bucket_priority_queue_tb.sv -----
// Self-checking testbench for the keyed priority queue with arrival order among equal priorities.
`timescale 1ns / 100ps

module indexed_bucket_priority_queue_tb;
  import ibpq_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 200;

  logic   clk;
  logic   rst;
  logic   start;
  req_t   req;
  logic   busy;
  logic   done;
  rsp_t   result;

  indexed_bucket_priority_queue DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  // Queue contents as the checker sees them: keys and priorities in arrival order.
  logic [KEY_W-1:0] held_keys[$];
  logic [PRI_W-1:0] held_pris[$];
  rsp_t             pending_rsp[$];
  int               fail_count;
  int               idle_cycles;

  // Row of the directed table; check_it marks a result typed in by hand.
  typedef struct {
    req_t req;
    bit   check_it;
    rsp_t rsp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int find_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < held_keys.size(); i++) begin
      if (held_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the queue contents and return the result it causes.
  function automatic rsp_t queue_apply(input req_t r);
    rsp_t o;
    int   s;
    o = '0;
    case (r.req_type)
      REQ_PUSH: begin
        s = find_slot(r.item_key);
        if (s >= 0) begin
          held_keys.delete(s);
          held_pris.delete(s);
        end
        if (held_keys.size() >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          held_keys.push_back(r.item_key);
          held_pris.push_back(r.priority_req);
        end
      end
      REQ_POP: begin
        s = -1;
        // Earliest arrival wins ties, so keep only strictly lower priorities.
        for (int i = 0; i < held_keys.size(); i++) begin
          if (s < 0 || held_pris[i] < held_pris[s]) s = i;
        end
        if (s < 0) begin
          o.status = ST_ABSENT;
        end else begin
          o.item_out = held_keys[s];
          held_keys.delete(s);
          held_pris.delete(s);
        end
      end
      REQ_ERASE: begin
        s = find_slot(r.item_key);
        if (s < 0) begin
          o.status = ST_ABSENT;
        end else begin
          held_keys.delete(s);
          held_pris.delete(s);
        end
      end
      REQ_FIND: begin
        s = find_slot(r.item_key);
        if (s < 0) o.status = ST_ABSENT;
        else o.item_out = r.item_key;
      end
      REQ_CLEAR: begin
        held_keys.delete();
        held_pris.delete();
      end
      default: ;
    endcase
    o.occupancy = OCC_W'(held_keys.size());
    return o;
  endfunction

  function automatic req_t make_req(input logic [2:0] code, input logic [KEY_W-1:0] key,
                                    input logic [PRI_W-1:0] pri);
    req_t r;
    r.req_type     = code;
    r.item_key     = key;
    r.priority_req = pri;
    return r;
  endfunction

  function automatic rsp_t make_rsp(input status_code_t st, input logic [ITEM_W-1:0] item,
                                    input int occ);
    rsp_t o;
    o.status    = st;
    o.item_out  = item;
    o.occupancy = OCC_W'(occ);
    return o;
  endfunction

  task automatic add_row(input req_t r, input bit chk, input rsp_t o);
    dir_row_t row;
    row.req      = r;
    row.check_it = chk;
    row.rsp      = o;
    dir_rows.push_back(row);
  endtask

  // Random gap before a beat: mostly none or short, now and then long; drop start over it.
  task automatic idle_gap();
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: n = 0;
      4, 5, 6, 7, 8: n = $urandom_range(3);
      default: n = $urandom_range(150, 20);
    endcase
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drive one beat, wait until the block is idle again, queue the expected result.
  task automatic send_req(input req_t r, input bit chk, input rsp_t o);
    rsp_t model_rsp;
    idle_gap();
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_rsp = queue_apply(r);
    if (chk && model_rsp !== o) begin
      $error("directed row disagrees with predictor: %h vs %h", o, model_rsp);
      fail_count++;
    end
    pending_rsp.push_back(model_rsp);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (held_keys.size() > 0 && $urandom_range(2) != 0)
      return held_keys[$urandom_range(held_keys.size() - 1)];
    if ($urandom_range(3) == 0) return $urandom;
    return KEY_W'($urandom_range(80));
  endfunction

  function automatic logic [PRI_W-1:0] pick_pri();
    case ($urandom_range(3))
      0: return PRI_W'($urandom);
      1: return {PRI_W{1'b1}};
      default: return PRI_W'($urandom_range(7));
    endcase
  endfunction

  // Check each result beat against the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result beat %h", result);
        fail_count++;
      end else begin
        want = pending_rsp[0];
        pending_rsp.delete(0);
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          fail_count++;
        end
        if (result.item_out !== want.item_out) begin
          $error("item_out: expected %h, got %h", want.item_out, result.item_out);
          fail_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, result.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat moving in either direction.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int   wait_count;
    int   code;
    req_t r;
    rst         = 1'b1;
    start       = 1'b0;
    req         = '0;
    fail_count  = 0;
    idle_cycles = 0;

    // Directed table: empty cases, extremes, ties, repush, clear, unused codes.
    add_row(make_req(REQ_POP, '0, '0), 1'b1, make_rsp(ST_ABSENT, '0, 0));
    add_row(make_req(REQ_FIND, '1, '0), 1'b1, make_rsp(ST_ABSENT, '0, 0));
    add_row(make_req(REQ_ERASE, 32'h5, '0), 1'b1, make_rsp(ST_ABSENT, '0, 0));
    add_row(make_req(REQ_PUSH, '1, '1), 1'b1, make_rsp(ST_OK, '0, 1));
    add_row(make_req(REQ_PUSH, '0, 16'h0), 1'b1, make_rsp(ST_OK, '0, 2));
    add_row(make_req(REQ_PUSH, 32'h1, 16'h7), 1'b1, make_rsp(ST_OK, '0, 3));
    add_row(make_req(REQ_PUSH, 32'h2, 16'h7), 1'b1, make_rsp(ST_OK, '0, 4));
    add_row(make_req(REQ_FIND, '1, '0), 1'b1, make_rsp(ST_OK, '1, 4));
    add_row(make_req(REQ_PUSH, 32'h1, 16'h7), 1'b0, '0);
    add_row(make_req(REQ_POP, '0, '0), 1'b1, make_rsp(ST_OK, '0, 3));
    add_row(make_req(REQ_POP, '0, '0), 1'b1, make_rsp(ST_OK, 32'h2, 2));
    add_row(make_req(REQ_ERASE, '1, '0), 1'b1, make_rsp(ST_OK, '0, 1));
    add_row(make_req(3'd5, '1, '1), 1'b1, make_rsp(ST_OK, '0, 1));
    add_row(make_req(3'd7, '0, '0), 1'b1, make_rsp(ST_OK, '0, 1));
    add_row(make_req(REQ_CLEAR, '0, '0), 1'b1, make_rsp(ST_OK, '0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].check_it, dir_rows[i].rsp);

    // Fill to capacity, then push a new key into the full queue and repush a held one.
    for (int k = 0; k < CAPACITY; k++)
      send_req(make_req(REQ_PUSH, 32'h1000 + k, k[PRI_W-1:0] % 4), 1'b0, '0);
    send_req(make_req(REQ_PUSH, 32'hDEAD_BEEF, '0), 1'b1, make_rsp(ST_FULL, '0, CAPACITY));
    send_req(make_req(REQ_PUSH, 32'h1000, '0), 1'b0, '0);
    send_req(make_req(REQ_CLEAR, '0, '0), 1'b1, make_rsp(ST_OK, '0, 0));

    // Random traffic, weighted toward pushes so the queue fills now and then.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(99))
        0:  code = REQ_CLEAR;
        1:  code = $urandom_range(7, 5);
        default: begin
          if ($urandom_range(99) < (held_keys.size() > 50 ? 35 : 55)) code = REQ_PUSH;
          else code = $urandom_range(3, 1);
        end
      endcase
      r = make_req(code[2:0], pick_key(), pick_pri());
      send_req(r, 1'b0, '0);
    end
    start <= 1'b0;

    // Drain and then allow the block's latency for stray beats.
    wait_count = 0;
    while (pending_rsp.size() != 0 && wait_count < 5000) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
